// ===== design/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

    // Number of entries in the sorted store.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // One access to the entry store: a write and a read in the same cycle.
    typedef struct packed {
        logic                     wr_en;
        addr_t                    wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        addr_t                    rd_addr;
    } mem_req_t;

    // Result of one command, as held by the controller.
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        cnt_t                     count;
    } res_t;

endpackage

// ===== design/sorted_list_engine.sv =====
`timescale 1ns / 1ps

// Sorted list engine: keeps up to 256 signed 32-bit values in ascending order
// in a single-port-write, single-port-read entry memory, plus an entry count.
// Each input beat carries a command (insert, remove, search, read at index)
// and produces exactly one output beat with ok, data and the count after the
// command. The engine works on one command at a time. Locating a position is
// a binary search in which each probe reads the memory in ST_SRCH_RD and then
// compares in ST_SRCH_CMP, until the window closes. Insert then moves every
// entry above the insertion point up by one and remove moves every entry
// above the removed one down by one, at one entry per cycle through the
// memory read and write ports, followed on insert by a store of the new
// value in ST_PUT. The memory needs no clearing pass after reset: only
// entries below the count are ever used. The output beat sits in a register,
// so the next command is taken while the last result waits.

module sorted_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    input  logic [7:0]          index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                ok,
    output logic signed [31:0]  data,
    output logic [8:0]          count
);

    sle_pkg::res_t      res;
    sle_pkg::mem_req_t  mem_req;
    logic               res_valid;
    logic               res_take;
    logic signed [31:0] rd_data;

    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic signed [31:0] data_reg;
    logic [8:0]         count_reg;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .index     (index),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // Entry store: one write and one registered read per cycle.
    sle_ram #(
        .WIDTH (sle_pkg::DATA_W),
        .DEPTH (sle_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // The output register takes a result whenever it is empty or its
    // beat leaves in this cycle.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            ok_reg    <= res.ok;
            data_reg  <= res.data;
            count_reg <= 9'(res.count);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign data      = data_reg;
    assign count     = count_reg;

endmodule

// ===== design/sle_ram.sv =====
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/sle_ctrl.sv =====
`timescale 1ns / 1ps

module sle_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic signed [31:0]       value,
    input  logic [7:0]               index,
    output logic                     res_valid,
    input  logic                     res_take,
    output sle_pkg::res_t            res,
    output sle_pkg::mem_req_t        mem_req,
    input  logic signed [31:0]       rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_UP,
        ST_DOWN,
        ST_PUT,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    sle_pkg::cmd_t        cmd_reg, cmd_next;
    logic signed [31:0]   val_reg, val_next;
    sle_pkg::cnt_t        cnt_reg, cnt_next;
    sle_pkg::cnt_t        lo_reg, lo_next;
    sle_pkg::cnt_t        hi_reg, hi_next;
    logic                 found_reg, found_next;
    sle_pkg::addr_t       ptr_reg, ptr_next;
    logic                 issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    sle_pkg::addr_t       pend_addr_reg, pend_addr_next;
    logic                 ok_reg, ok_next;
    logic signed [31:0]   data_reg, data_next;
    sle_pkg::cnt_t        mid;

    // Midpoint of the open search window [lo, hi).
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.ok    = ok_reg;
    assign res.data  = data_reg;
    assign res.count = cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        found_next     = found_reg;
        ptr_next       = ptr_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        ok_next        = ok_reg;
        data_next      = data_reg;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = pend_addr_reg;
        mem_req.wr_data = rd_data;
        mem_req.rd_addr = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.rd_addr = sle_pkg::addr_t'(index);
                if (in_valid)
                begin
                    cmd_next   = sle_pkg::cmd_t'(cmd);
                    val_next   = value;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    data_next  = '0;
                    unique case (sle_pkg::cmd_t'(cmd))
                        sle_pkg::CMD_INSERT:
                        begin
                            if (cnt_reg == sle_pkg::cnt_t'(sle_pkg::DEPTH))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        sle_pkg::CMD_REMOVE,
                        sle_pkg::CMD_SEARCH:
                        begin
                            state_next = ST_SRCH_RD;
                        end
                        sle_pkg::CMD_READ:
                        begin
                            if (int'(index) < int'(cnt_reg))
                            begin
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SRCH_RD:
            begin
                mem_req.rd_addr = sle_pkg::addr_t'(mid);
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    unique case (cmd_reg)
                        sle_pkg::CMD_INSERT:
                        begin
                            if (lo_reg == cnt_reg)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                ptr_next   = sle_pkg::addr_t'(cnt_reg - 1'b1);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = ST_UP;
                            end
                        end
                        sle_pkg::CMD_REMOVE:
                        begin
                            if (!found_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (lo_reg + 1'b1 == cnt_reg)
                            begin
                                cnt_next   = cnt_reg - 1'b1;
                                ok_next    = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ptr_next   = sle_pkg::addr_t'(lo_reg + 1'b1);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = ST_DOWN;
                            end
                        end
                        sle_pkg::CMD_SEARCH:
                        begin
                            ok_next    = found_reg;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SRCH_CMP:
            begin
                if (cmd_reg == sle_pkg::CMD_INSERT)
                begin
                    // Upper bound: the new value lands after equal entries.
                    if (val_reg < rd_data)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + 1'b1;
                    end
                end
                else
                begin
                    // Lower bound: lo ends on the first entry not below the value.
                    if (rd_data < val_reg)
                    begin
                        lo_next = mid + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                    if (rd_data == val_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                state_next = ST_SRCH_RD;
            end

            ST_UP:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_addr_reg + 1'b1;
                end
                if (issue_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    if (sle_pkg::cnt_t'(ptr_reg) == lo_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_PUT;
                end
            end

            ST_DOWN:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_addr_reg - 1'b1;
                end
                if (issue_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    if (sle_pkg::cnt_t'(ptr_reg) + 1'b1 == cnt_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = cnt_reg - 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sle_pkg::addr_t'(lo_reg);
                mem_req.wr_data = val_reg;
                cnt_next        = cnt_reg + 1'b1;
                ok_next         = 1'b1;
                state_next      = ST_DONE;
            end

            ST_RD_WAIT:
            begin
                data_next  = rd_data;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        found_reg     <= found_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        ok_reg        <= ok_next;
        data_reg      <= data_next;
    end

    // The count never runs past the store size.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sle_pkg::cnt_t'(sle_pkg::DEPTH))
        else $error("entry count exceeds store depth");

    // The search window never inverts.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_RD || state_reg == ST_SRCH_CMP) |-> lo_reg <= hi_reg)
        else $error("search window inverted");

    // While shifting, the write never hits the entry being read in the same cycle.
    a_shift_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UP || state_reg == ST_DOWN) && mem_req.wr_en)
            |-> mem_req.wr_addr != mem_req.rd_addr)
        else $error("shift write collides with shift read");

    // A pending result blocks new commands.
    a_res_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_stall)
        else $error("input accepted while result pending");

endmodule

// ===== test/sorted_list_engine_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted list engine.
//
// An initial block builds a queue of command beats up front: a short directed
// opening, then a random middle section that grows the list, fills it to
// capacity, hammers the full store, and finally drains it again. A clocked
// driver feeds those beats to the engine in bursts with random gaps, and a
// clocked monitor keeps a shadow copy of the sorted store. For every accepted
// command it works out the expected result, and it checks every result beat
// against the oldest outstanding expectation.
module sorted_list_engine_tb;

    // The slowest command shifts a full store. The limit below covers
    // every beat being that slow, plus sender gaps and receiver stalls,
    // several times over.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        sle_pkg::cmd_t      op;
        logic signed [31:0] value;
        logic [7:0]         index;
        bit                 hold;   // wait for all results before sending
    } cmd_beat_t;

    typedef enum {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_SOLID
    } stall_mode_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = sle_pkg::CMD_READ;
    logic signed [31:0] value = '0;
    logic [7:0]         index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic signed [31:0] data;
    logic [8:0]         count;

    // Beats still to be sent, and the multiset of values that the stimulus
    // generator believes is stored once those beats have run. The latter only
    // steers the random choices; checking uses the shadow store alone.
    cmd_beat_t          pending_beats[$];
    logic signed [31:0] planned_values[$];

    // Shadow of the engine's sorted store and the results still owed by it.
    logic signed [31:0] shadow_list[$];
    sle_pkg::res_t      expected_results[$];

    logic               in_fire = 1'b0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    stall_mode_t        stall_mode = STALL_NONE;
    int                 stall_left = 0;
    int                 cycle_count = 0;
    int                 mismatch_count = 0;
    int                 beats_by_op[4] = '{0, 0, 0, 0};
    int                 ok_count = 0;
    int                 full_refusals = 0;
    int                 peak_count = 0;

    sorted_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .index     (index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .data      (data),
        .count     (count)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Applies one command to the shadow store and returns the result beat
    // that the engine owes for it. Insert lands after every entry that is
    // less than or equal to the value; remove takes the first equal entry.
    function automatic sle_pkg::res_t apply_to_shadow(cmd_beat_t b);
        sle_pkg::res_t r;
        int            pos;
        int            hit;
        r.ok   = 1'b0;
        r.data = '0;
        case (b.op)
            sle_pkg::CMD_INSERT:
            begin
                if (shadow_list.size() < sle_pkg::DEPTH)
                begin
                    pos = 0;
                    while (pos < shadow_list.size() && shadow_list[pos] <= b.value)
                        pos++;
                    shadow_list.insert(pos, b.value);
                    r.ok = 1'b1;
                end
            end
            sle_pkg::CMD_REMOVE:
            begin
                hit = -1;
                foreach (shadow_list[i])
                    if (hit < 0 && shadow_list[i] == b.value)
                        hit = i;
                if (hit >= 0)
                begin
                    shadow_list.delete(hit);
                    r.ok = 1'b1;
                end
            end
            sle_pkg::CMD_SEARCH:
            begin
                foreach (shadow_list[i])
                    if (shadow_list[i] == b.value)
                        r.ok = 1'b1;
            end
            default:
            begin
                if (int'(b.index) < shadow_list.size())
                    r.data = shadow_list[b.index];
            end
        endcase
        r.count = sle_pkg::cnt_t'(shadow_list.size());
        return r;
    endfunction

    // Values are drawn from what is stored four times in ten, so that removes and
    // searches hit, and otherwise from a narrow band around zero (to make
    // duplicates), the signed extremes, or the whole 32-bit range.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                if (planned_values.size() > 0)
                    v = planned_values[$urandom_range(0, planned_values.size() - 1)];
                else
                    v = $urandom_range(0, 20) - 10;
            4, 5, 6:
                v = $urandom_range(0, 20) - 10;
            7:
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    default: v = -32'sd1;
                endcase
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_beat(sle_pkg::cmd_t op, logic signed [31:0] v, logic [7:0] idx,
                              bit hold);
        cmd_beat_t b;
        int        hit;
        b.op    = op;
        b.value = v;
        b.index = idx;
        b.hold  = hold;
        pending_beats.push_back(b);
        hit = -1;
        if (op == sle_pkg::CMD_INSERT && planned_values.size() < sle_pkg::DEPTH)
            planned_values.push_back(v);
        else if (op == sle_pkg::CMD_REMOVE)
        begin
            foreach (planned_values[i])
                if (hit < 0 && planned_values[i] == v)
                    hit = i;
            if (hit >= 0)
                planned_values.delete(hit);
        end
    endtask

    // Weights are percentages for insert, remove and search; the rest of
    // the hundred goes to reads. Half the reads aim inside the list.
    task automatic queue_random(int w_ins, int w_rem, int w_find);
        int            r;
        sle_pkg::cmd_t op;
        logic [7:0]    idx;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            op = sle_pkg::CMD_INSERT;
        else if (r < w_ins + w_rem)
            op = sle_pkg::CMD_REMOVE;
        else if (r < w_ins + w_rem + w_find)
            op = sle_pkg::CMD_SEARCH;
        else
            op = sle_pkg::CMD_READ;
        if ($urandom_range(0, 1) == 1 && planned_values.size() > 0)
            idx = 8'($urandom_range(0, planned_values.size() - 1));
        else
            idx = 8'($urandom);
        queue_beat(op, pick_value(), idx, $urandom_range(0, 39) == 0);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin
        // Directed opening: empty-store search, remove and read, the signed
        // extremes, a duplicate, reads at and past the ends, hits and misses.
        queue_beat(sle_pkg::CMD_SEARCH, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd0, 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sh8000_0000, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, -32'sd1, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sd1, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd0, 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd5, 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd6, 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd255, 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, 32'sh7FFF_FFFF, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, 32'sh8000_0000, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, 32'sd2, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, -32'sd2, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, 32'sd0, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, 32'sd5, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, 32'sh7FFF_FFFF, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, 32'sh8000_0000, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd0, 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 8'($urandom), 1'b0);

        // Random growth with every command mixed in. The first random beat
        // waits for the engine to go quiet.
        queue_beat(sle_pkg::CMD_SEARCH, pick_value(), 8'($urandom), 1'b1);
        while (pending_beats.size() < 220)
            queue_random(40, 25, 20);

        // Fill the store to capacity, with searches and reads in between.
        while (planned_values.size() < sle_pkg::DEPTH)
        begin
            if ($urandom_range(0, 5) == 0)
                queue_random(0, 0, 50);
            else
                queue_beat(sle_pkg::CMD_INSERT, pick_value(), 8'($urandom), 1'b0);
        end

        // Full store: inserts are refused, reads reach the last index.
        queue_beat(sle_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 8'($urandom), 1'b1);
        queue_beat(sle_pkg::CMD_INSERT, 32'sh8000_0000, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, $urandom, 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd255, 1'b0);
        queue_beat(sle_pkg::CMD_READ, $urandom, 8'd0, 1'b0);
        queue_beat(sle_pkg::CMD_SEARCH, pick_value(), 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_REMOVE, pick_value(), 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, pick_value(), 8'($urandom), 1'b0);
        queue_beat(sle_pkg::CMD_INSERT, pick_value(), 8'($urandom), 1'b0);

        // Drain: mostly removes, so the list shrinks back down.
        while (pending_beats.size() < 650)
            queue_random(20, 50, 15);

        // Reset is released on a falling edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // Give any stray result beat time to show up.
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d inserts (%0d refused on a full store), %0d removes,",
                 beats_by_op[sle_pkg::CMD_INSERT], full_refusals,
                 beats_by_op[sle_pkg::CMD_REMOVE]);
        $display("%0d searches and %0d reads; %0d succeeded, peak list %0d, %0d mismatches.",
                 beats_by_op[sle_pkg::CMD_SEARCH], beats_by_op[sle_pkg::CMD_READ],
                 ok_count, peak_count, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sorted_list_engine_tb passed");
        else
            $display("sorted_list_engine_tb failed");
        $finish;
    end

    // Sender. A new beat is chosen only when the line is idle or the beat
    // on it was just taken, so a stalled payload never moves. Beats go out
    // in bursts of random length separated by random gaps, and a beat marked
    // as a hold waits until the engine owes no result.
    always @(negedge clk)
    begin : sender
        cmd_beat_t b;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() == 0
                     || (pending_beats[0].hold && expected_results.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                b = pending_beats.pop_front();
                in_valid <= 1'b1;
                cmd      <= b.op;
                value    <= b.value;
                index    <= b.index;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0: gap_left <= 0;
                        1: gap_left <= $urandom_range(1, 3);
                        2: gap_left <= $urandom_range(5, 25);
                        default: gap_left <= 0;
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver. The stall pattern switches between free flow, heavy and
    // light random stalls, and solid stall stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(5, 60);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:     out_stall <= (stall_left > 30);
        endcase
    end

    // Monitor. Results are checked before the command taken at the same edge
    // is predicted; the engine cannot answer a command in the cycle that it
    // accepts it, so that order keeps the expectations in step.
    always @(posedge clk)
    begin : monitor
        sle_pkg::res_t want;
        sle_pkg::res_t r;
        cmd_beat_t     b;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing outstanding: %s",
                                 $realtime,
                                 $sformatf("ok=%0b data=%0d count=%0d", ok, data, count));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ok !== want.ok || data !== want.data || count !== want.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: expected ok=%0b data=%0d count=%0d, %s",
                                     $realtime, want.ok, $signed(want.data), want.count,
                                     $sformatf("got ok=%0b data=%0d count=%0d",
                                               ok, data, count));
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                b.op    = sle_pkg::cmd_t'(cmd);
                b.value = value;
                b.index = index;
                b.hold  = 1'b0;
                r = apply_to_shadow(b);
                expected_results.push_back(r);
                beats_by_op[b.op]++;
                if (r.ok)
                    ok_count++;
                if (b.op == sle_pkg::CMD_INSERT && !r.ok)
                    full_refusals++;
                if (int'(r.count) > peak_count)
                    peak_count = r.count;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d beats unsent and %0d results owed.",
                     cycle_count, pending_beats.size(), expected_results.size());
            $display("sorted_list_engine_tb failed");
            $finish;
        end
    end

endmodule
